// ===== sv/tls_certificate_msg_framer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// tls_certificate_msg_framer_unit_defines.svh
// Assertion macros shared by the framer's checker.
// ----------------------------------------------------------------------------
`ifndef TLS_CERTIFICATE_MSG_FRAMER_UNIT_DEFINES_SVH
`define TLS_CERTIFICATE_MSG_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define TCMF_ASSERT_SAME(label, clk, rst, ante, cons, text) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(text);

// Next-cycle implication, off while reset is high
`define TCMF_ASSERT_NEXT(label, clk, rst, ante, cons, text) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(text);

// Next-cycle implication that also runs through reset
`define TCMF_ASSERT_ALWAYS(label, clk, ante, cons, text) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(text);

`endif

// ===== sv/tcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcmf_pkg
// Types and constants of the TLS 1.3 Certificate message framer.
// ----------------------------------------------------------------------------
package tcmf_pkg;

  // Field widths of the message format and of the result words
  localparam int LEN_W   = 24;
  localparam int EXT_W   = 16;
  localparam int POS_W   = 25;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int FBC_W   = 2;

  // Default limit on certificates in one chain
  localparam int CHAIN_LIMIT_DEF = 16;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MAX_CERT = 1'b0;   // register index, paddr[2]
  localparam logic [LEN_W-1:0] MAX_CERT_RESET = LEN_W'(8192);

  // Byte position saturates here
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Shortest tail that can still hold a field
  localparam logic [LEN_W-1:0] CERTLEN_BYTES = LEN_W'(3);
  localparam logic [LEN_W-1:0] EXTLEN_BYTES  = LEN_W'(2);
  localparam logic [EXT_W-1:0] EXTHDR_BYTES  = EXT_W'(4);

  typedef enum logic [3:0] {
    PH_CTX,
    PH_LISTLEN,
    PH_CERTLEN,
    PH_BODY,
    PH_EXTLEN,
    PH_EXTHDR,
    PH_EXTDATA,
    PH_LISTEND,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_PARSE,
    ST_TOO_LONG,
    ST_TOO_LARGE
  } status_t;

  typedef enum logic {
    KIND_CERT,
    KIND_FINAL
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t              record_kind;
    logic [IDX_W-1:0]   cert_index;
    logic [POS_W-1:0]   cert_offset;
    logic [LEN_W-1:0]   cert_length;
    logic [CNT_W-1:0]   cert_count;
    status_t            status;
    logic               last_result;
  } rec_t;

  // Results of one byte, handed to the result queue
  typedef struct packed {
    logic [1:0] n;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

// ===== sv/tcmf_if.sv =====
// ----------------------------------------------------------------------------
// tcmf_byte_if / tcmf_rec_if
// Valid/ready channels for message bytes and for result words.
// ----------------------------------------------------------------------------
interface tcmf_byte_if import tcmf_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tcmf_rec_if import tcmf_pkg::*;;
  logic             valid;
  logic             ready;
  logic             record_kind;
  logic [IDX_W-1:0] cert_index;
  logic [POS_W-1:0] cert_offset;
  logic [LEN_W-1:0] cert_length;
  logic [CNT_W-1:0] cert_count;
  logic [1:0]       status;
  logic             last_result;

  modport source (output valid, record_kind, cert_index, cert_offset, cert_length,
                  cert_count, status, last_result, input ready);
  modport sink   (input valid, record_kind, cert_index, cert_offset, cert_length,
                  cert_count, status, last_result, output ready);
endinterface

// ===== sv/tls_certificate_msg_framer_unit.sv =====
// ----------------------------------------------------------------------------
// tls_certificate_msg_framer_unit
// Framing checker for TLS 1.3 Certificate message bodies.
// ----------------------------------------------------------------------------
// The unit takes one message byte per clock on msg while msg.ready is high
// and reports on rec a boundary word (index, offset, length) as each
// certificate body ends and a final status word on the byte marked last.
// Every byte is parsed in the cycle it is accepted, and its words are
// registered into a four-word result queue whose head drives rec.
// msg.ready drops while three or more words wait, so a consumer that is
// always ready never stalls the input, and a stalled consumer holds it
// with at most four words queued. The certificate size limit sits at APB
// byte address 0; the user must write it between messages, not enforced.
module tls_certificate_msg_framer_unit import tcmf_pkg::*; #(
  parameter int CHAIN_LIMIT = CHAIN_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  tcmf_byte_if.sink          msg,
  tcmf_rec_if.source         rec,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [LEN_W-1:0] max_cert_bytes;
  logic             room;
  logic             accept;
  push_t            push;
  rec_t             head;
  logic             head_valid;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cert_bytes <= MAX_CERT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_CERT)) begin
      max_cert_bytes <= pwdata[LEN_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_MAX_CERT) ?
                  {{(PDATA_W-LEN_W){1'b0}}, max_cert_bytes} : '0;

  // Input handshake
  assign msg.ready = room;
  assign accept    = msg.valid && room;

  tcmf_parser #(
    .CHAIN_LIMIT(CHAIN_LIMIT)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (msg.data_byte),
    .last_byte     (msg.last_byte),
    .max_cert_bytes(max_cert_bytes),
    .push          (push)
  );

  tcmf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .head_valid(head_valid),
    .head_ready(rec.ready),
    .head      (head)
  );

  // Drive the result channel from the queue head
  assign rec.valid       = head_valid;
  assign rec.record_kind = head.record_kind;
  assign rec.cert_index  = head.cert_index;
  assign rec.cert_offset = head.cert_offset;
  assign rec.cert_length = head.cert_length;
  assign rec.cert_count  = head.cert_count;
  assign rec.status      = head.status;
  assign rec.last_result = head.last_result;

endmodule

// ===== sv/tcmf_parser.sv =====
// ----------------------------------------------------------------------------
// tcmf_parser
// Parse state of the Certificate message; one byte per accepted word.
// ----------------------------------------------------------------------------
module tcmf_parser import tcmf_pkg::*; #(
  parameter int CHAIN_LIMIT = CHAIN_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [LEN_W-1:0] max_cert_bytes,
  output push_t            push
);

  phase_t           phase, phase_next;
  logic [FBC_W-1:0] fbc, fbc_next;
  logic [LEN_W-1:0] acc, acc_next;
  logic [LEN_W-1:0] list_rem, list_rem_next;
  logic [LEN_W-1:0] body_rem, body_rem_next;
  logic [EXT_W-1:0] ext_blk, ext_blk_next;
  logic [EXT_W-1:0] ext_dat, ext_dat_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [POS_W-1:0] cert_start, cert_start_next;
  logic [CNT_W-1:0] certs, certs_next;
  status_t          kept_err, kept_err_next;

  logic [LEN_W-1:0] acc_shift24;
  logic [EXT_W-1:0] acc_shift16;
  logic [LEN_W-1:0] list_dec, body_dec, entry_lr;
  logic [EXT_W-1:0] ext_blk_dec, ext_dat_dec, ext_src;
  status_t          err;
  logic             do_ext, do_entry, bnd, done;
  rec_t             rec_bnd, rec_fin;

  // Shifted length fields and saturating down counts
  assign acc_shift24 = {acc[LEN_W-9:0], data_byte};
  assign acc_shift16 = {acc[7:0], data_byte};
  assign list_dec    = (list_rem != '0) ? list_rem - 1'b1 : '0;
  assign body_dec    = (body_rem != '0) ? body_rem - 1'b1 : '0;
  assign ext_blk_dec = (ext_blk != '0) ? ext_blk - 1'b1 : '0;
  assign ext_dat_dec = (ext_dat != '0) ? ext_dat - 1'b1 : '0;

  // List bytes left when an entry closes, extension bytes left when a record closes
  assign entry_lr = (phase == PH_LISTLEN) ? acc_shift24 : list_dec;
  assign ext_src  = (phase == PH_EXTLEN) ? acc_shift16 : ext_blk_dec;

  // Next parse state for one byte
  always_comb begin
    phase_next      = phase;
    fbc_next        = fbc;
    acc_next        = acc;
    list_rem_next   = list_rem;
    body_rem_next   = body_rem;
    ext_blk_next    = ext_blk;
    ext_dat_next    = ext_dat;
    cert_start_next = cert_start;
    certs_next      = certs;
    kept_err_next   = kept_err;
    err             = ST_OK;
    do_ext          = 1'b0;
    do_entry        = 1'b0;
    bnd             = 1'b0;

    case (phase)
      PH_CTX: begin
        if (data_byte != 8'd0) begin
          err = ST_PARSE;
        end else begin
          phase_next = PH_LISTLEN;
          fbc_next   = '0;
          acc_next   = '0;
        end
      end
      PH_LISTLEN: begin
        acc_next = acc_shift24;
        if (fbc == FBC_W'(2)) begin
          list_rem_next = acc_shift24;
          do_entry      = 1'b1;
        end else begin
          fbc_next = fbc + 1'b1;
        end
      end
      PH_CERTLEN: begin
        list_rem_next = list_dec;
        acc_next      = acc_shift24;
        if (fbc == FBC_W'(2)) begin
          if (acc_shift24 == '0) begin
            err = ST_PARSE;
          end else if (acc_shift24 > max_cert_bytes) begin
            err = ST_TOO_LARGE;
          end else if (acc_shift24 > list_dec) begin
            err = ST_PARSE;
          end else begin
            certs_next      = certs + 1'b1;
            cert_start_next = byte_pos + 1'b1;
            body_rem_next   = acc_shift24;
            phase_next      = PH_BODY;
          end
        end else begin
          fbc_next = fbc + 1'b1;
        end
      end
      PH_BODY: begin
        list_rem_next = list_dec;
        body_rem_next = body_dec;
        if (body_dec == '0) begin
          bnd = 1'b1;
          if (list_dec < EXTLEN_BYTES) begin
            err = ST_PARSE;
          end else begin
            phase_next = PH_EXTLEN;
            fbc_next   = '0;
            acc_next   = '0;
          end
        end
      end
      PH_EXTLEN: begin
        list_rem_next = list_dec;
        acc_next      = {{(LEN_W-EXT_W){1'b0}}, acc_shift16};
        if (fbc == FBC_W'(1)) begin
          if ({{(LEN_W-EXT_W){1'b0}}, acc_shift16} > list_dec) begin
            err = ST_PARSE;
          end else begin
            ext_blk_next = acc_shift16;
            do_ext       = 1'b1;
          end
        end else begin
          fbc_next = fbc + 1'b1;
        end
      end
      PH_EXTHDR: begin
        list_rem_next = list_dec;
        ext_blk_next  = ext_blk_dec;
        acc_next      = {{(LEN_W-EXT_W){1'b0}}, acc_shift16};
        if (fbc == FBC_W'(3)) begin
          if (acc_shift16 > ext_blk_dec) begin
            err = ST_PARSE;
          end else begin
            ext_dat_next = acc_shift16;
            if (acc_shift16 == '0) begin
              do_ext = 1'b1;
            end else begin
              phase_next = PH_EXTDATA;
            end
          end
        end else begin
          fbc_next = fbc + 1'b1;
        end
      end
      PH_EXTDATA: begin
        list_rem_next = list_dec;
        ext_blk_next  = ext_blk_dec;
        ext_dat_next  = ext_dat_dec;
        if (ext_dat_dec == '0) begin
          do_ext = 1'b1;
        end
      end
      PH_LISTEND: begin
        err = ST_PARSE;
      end
      default: begin
      end
    endcase

    // Close an extension record: end of entry, short tail, or next header
    if (do_ext) begin
      if (ext_src == '0) begin
        do_entry = 1'b1;
      end else if (ext_src < EXTHDR_BYTES) begin
        err = ST_PARSE;
      end else begin
        phase_next = PH_EXTHDR;
        fbc_next   = '0;
        acc_next   = '0;
      end
    end

    // Close an entry: end of list, chain limit, short tail, or next length
    if (do_entry) begin
      if (entry_lr == '0) begin
        phase_next = PH_LISTEND;
      end else if (certs >= CNT_W'(CHAIN_LIMIT)) begin
        err = ST_TOO_LONG;
      end else if (entry_lr < CERTLEN_BYTES) begin
        err = ST_PARSE;
      end else begin
        phase_next = PH_CERTLEN;
        fbc_next   = '0;
        acc_next   = '0;
      end
    end

    // Keep the first error and drain until the last byte
    if (err != ST_OK) begin
      phase_next = PH_DRAIN;
      if (kept_err == ST_OK) begin
        kept_err_next = err;
      end
    end
  end

  assign byte_pos_next = (byte_pos != POS_MAX) ? byte_pos + 1'b1 : byte_pos;
  assign done = (phase_next == PH_LISTEND) && (certs_next != '0);

  // Build the boundary and final status words
  always_comb begin
    rec_bnd             = '0;
    rec_bnd.record_kind = KIND_CERT;
    rec_bnd.cert_index  = IDX_W'(certs - 1'b1);
    rec_bnd.cert_offset = cert_start;
    rec_bnd.cert_length = acc;
    rec_bnd.status      = ST_OK;

    rec_fin             = '0;
    rec_fin.record_kind = KIND_FINAL;
    rec_fin.cert_count  = certs_next;
    rec_fin.last_result = 1'b1;
    if (kept_err_next != ST_OK) begin
      rec_fin.status = kept_err_next;
    end else begin
      rec_fin.status = done ? ST_OK : ST_PARSE;
    end
  end

  // Hand the byte's results to the queue, boundary first
  always_comb begin
    push.n    = accept ? (2'(bnd) + 2'(last_byte)) : 2'd0;
    push.rec0 = bnd ? rec_bnd : rec_fin;
    push.rec1 = rec_fin;
  end

  // Advance the parse state on each accepted byte; clear it after the last
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase      <= PH_CTX;
      fbc        <= '0;
      acc        <= '0;
      list_rem   <= '0;
      body_rem   <= '0;
      ext_blk    <= '0;
      ext_dat    <= '0;
      byte_pos   <= '0;
      cert_start <= '0;
      certs      <= '0;
      kept_err   <= ST_OK;
    end else if (accept) begin
      phase      <= phase_next;
      fbc        <= fbc_next;
      acc        <= acc_next;
      list_rem   <= list_rem_next;
      body_rem   <= body_rem_next;
      ext_blk    <= ext_blk_next;
      ext_dat    <= ext_dat_next;
      byte_pos   <= byte_pos_next;
      cert_start <= cert_start_next;
      certs      <= certs_next;
      kept_err   <= kept_err_next;
    end
  end

endmodule

// ===== sv/tcmf_out_queue.sv =====
// ----------------------------------------------------------------------------
// tcmf_out_queue
// Four-word result queue; takes up to two words per cycle, gives one while the consumer is ready.
// ----------------------------------------------------------------------------
module tcmf_out_queue import tcmf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  input  logic  head_ready,
  output rec_t  head
);

  rec_t       entries [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;

  // Room for a byte that makes two words
  assign room       = (count <= 3'd2);
  assign head_valid = (count != 3'd0);
  assign head       = entries[rp];
  assign pop        = head_valid && head_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.n;
      rp    <= rp + 2'(pop);
      count <= count + 3'(push.n) - 3'(pop);
    end
  end

  // Write the new words
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wp] <= push.rec0;
    end
    if (push.n == 2'd2) begin
      entries[wp + 2'd1] <= push.rec1;
    end
  end

endmodule

// ===== sv/tcmf_checker.sv =====
// ----------------------------------------------------------------------------
// tcmf_checker
// Port-level checks of the framer's result channel.
// ----------------------------------------------------------------------------
`include "tls_certificate_msg_framer_unit_defines.svh"

module tcmf_checker import tcmf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             rec_valid,
  input logic             rec_ready,
  input logic             record_kind,
  input logic [LEN_W-1:0] cert_length,
  input logic [CNT_W-1:0] cert_count,
  input logic [1:0]       status,
  input logic             last_result
);

  // Stalled word holds
  `TCMF_ASSERT_NEXT(a_hold, clk, rst, rec_valid && !rec_ready, rec_valid && $stable(record_kind) && $stable(cert_length) && $stable(status), "stalled result word changed")

  // Only a final status word closes a message
  `TCMF_ASSERT_SAME(a_last_kind, clk, rst, rec_valid && last_result, record_kind, "last mark on a boundary word")

  // Boundary words carry a nonzero length and no status or count
  `TCMF_ASSERT_SAME(a_bnd_fields, clk, rst, rec_valid && !record_kind, (cert_length != '0) && (cert_count == '0) && (status == 2'd0) && !last_result, "malformed boundary word")

  // Queue is empty after reset
  `TCMF_ASSERT_ALWAYS(a_rst_empty, clk, rst, !rec_valid, "result word right after reset")

endmodule

bind tls_certificate_msg_framer_unit tcmf_checker u_tcmf_checker (
  .clk        (clk),
  .rst        (rst),
  .rec_valid  (rec.valid),
  .rec_ready  (rec.ready),
  .record_kind(rec.record_kind),
  .cert_length(rec.cert_length),
  .cert_count (rec.cert_count),
  .status     (rec.status),
  .last_result(rec.last_result)
);
